>>> src/bb3_pkg.sv
// Shared constants, command/status types and the reciprocal table for the 3x3 box blur.
package bb3_pkg;

  // Frame limits and field widths
  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;
  localparam int DimW      = 11;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight);
  localparam int IrowW     = RowW + 1;          // input row runs a little past the frame
  localparam int IpW       = ColW + RowW + 1;   // input steps, frame plus flush shifts
  localparam int OpW       = ColW + RowW;
  localparam int ChW       = 8;
  localparam int PixW      = 3 * ChW;

  // Averaging arithmetic
  localparam int SumW      = 12;                // 9 * 255
  localparam int NW        = 4;                 // 1..9 neighbors
  localparam int XW        = SumW + 1;          // 2*sum + n
  localparam int RecipK    = 20;
  localparam int RecipW    = 20;
  localparam int ProdW     = XW + RecipW;

  // Configuration registers
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgImageWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgImageHeight = 1'b1;
  localparam logic [DimW-1:0] WidthReset  = DimW'(640);
  localparam logic [DimW-1:0] HeightReset = DimW'(480);

  typedef struct packed {
    logic capture;   // input beat accepted, latch pixel
    logic shift;     // one window shift and line store update
    logic zero_pix;  // shift in a zero pixel (flush)
    logic sum;       // register neighborhood sums
    logic load;      // divide and load the output register
  } bb3_cmd_t;

  typedef struct packed {
    logic in_done;    // whole frame has arrived
    logic emit_due;   // next pixel shift completes an output window
    logic need_shift; // flush must shift once more before emitting
    logic out_free;   // output register can take a result
  } bb3_status_t;

  // ceil(2^RecipK / (2n)); exact quotient for all 2*sum+n below 2^XW
  function automatic logic [RecipW-1:0] recip(input logic [NW-1:0] n);
    logic [RecipW-1:0] r;
    case (n)
      4'd1:    r = RecipW'(524288);
      4'd2:    r = RecipW'(262144);
      4'd3:    r = RecipW'(174763);
      4'd4:    r = RecipW'(131072);
      4'd5:    r = RecipW'(104858);
      4'd6:    r = RecipW'(87382);
      4'd7:    r = RecipW'(74899);
      4'd8:    r = RecipW'(65536);
      4'd9:    r = RecipW'(58255);
      default: r = RecipW'(524288);
    endcase
    return r;
  endfunction

endpackage

>>> src/bb3_ctrl.sv
// Sequencer for the 3x3 box blur: accepts beats and steps the datapath.
module bb3_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 opcode_i,
  output logic                 in_stall_o,
  input  bb3_pkg::bb3_status_t status_i,
  output bb3_pkg::bb3_cmd_t    cmd_o
);
  import bb3_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SHIFT,
    ST_CHECK,
    ST_SUM,
    ST_DIV
  } state_e;

  state_e state_q, state_d;
  logic   emit_q, emit_d;
  logic   flush_q, flush_d;
  logic   accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  // Commands to the datapath
  always_comb begin
    cmd_o          = '0;
    cmd_o.capture  = accept;
    cmd_o.shift    = (state_q == ST_SHIFT);
    cmd_o.zero_pix = flush_q;
    cmd_o.sum      = (state_q == ST_SUM);
    cmd_o.load     = (state_q == ST_DIV) && status_i.out_free;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    emit_d  = emit_q;
    flush_d = flush_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (status_i.in_done) begin
            // frame complete: any beat acts as a flush
            flush_d = 1'b1;
            state_d = ST_CHECK;
          end else if (opcode_i == 1'b0) begin
            flush_d = 1'b0;
            emit_d  = status_i.emit_due;
            state_d = ST_READ;
          end
        end
      end
      ST_READ:  state_d = ST_SHIFT;
      ST_SHIFT: begin
        if (flush_q)     state_d = ST_CHECK;
        else if (emit_q) state_d = ST_SUM;
        else             state_d = ST_IDLE;
      end
      ST_CHECK: state_d = status_i.need_shift ? ST_READ : ST_SUM;
      ST_SUM:   state_d = ST_DIV;
      ST_DIV: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      emit_q  <= 1'b0;
      flush_q <= 1'b0;
    end else begin
      state_q <= state_d;
      emit_q  <= emit_d;
      flush_q <= flush_d;
    end
  end

endmodule

>>> src/bb3_datapath.sv
// Line stores, window, position counters, averaging and output register of the box blur.
module bb3_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bb3_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [bb3_pkg::DimW-1:0]         cfg_data_i,
  input  logic [bb3_pkg::ChW-1:0]          red_i,
  input  logic [bb3_pkg::ChW-1:0]          green_i,
  input  logic [bb3_pkg::ChW-1:0]          blue_i,
  input  bb3_pkg::bb3_cmd_t                cmd_i,
  output bb3_pkg::bb3_status_t             status_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [bb3_pkg::ChW-1:0]          red_out_o,
  output logic [bb3_pkg::ChW-1:0]          green_out_o,
  output logic [bb3_pkg::ChW-1:0]          blue_out_o,
  output logic                             frame_last_o
);
  import bb3_pkg::*;

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v, input int maxv);
    logic [DimW-1:0] r;
    if (v == '0)                r = DimW'(1);
    else if (v > DimW'(maxv))   r = DimW'(maxv);
    else                        r = v;
    return r;
  endfunction

  logic [DimW-1:0]  w_q, h_q;
  logic [PixW-1:0]  pix_q;
  logic [ColW-1:0]  icol_q;
  logic [IrowW-1:0] irow_q;
  logic [IpW-1:0]   ip_q;
  logic [ColW-1:0]  ocol_q;
  logic [RowW-1:0]  orow_q;
  logic [OpW-1:0]   op_q;
  logic [PixW-1:0]  win_q [3][3];
  logic [PixW-1:0]  above_mem [MaxWidth];
  logic [PixW-1:0]  two_above_mem [MaxWidth];
  logic [PixW-1:0]  mid_rd_q, top_rd_q;
  logic [SumW-1:0]  sum_q [3];
  logic [SumW-1:0]  sum_d [3];
  logic [NW-1:0]    n_q, n_d;
  logic [ChW-1:0]   quot [3];
  logic [ChW-1:0]   red_q, green_q, blue_q;
  logic             last_q, out_valid_q;

  logic [PixW-1:0]  shift_pix;
  logic             icol_last, ocol_last, orow_last, frame_end, restart;
  logic             row_ok [3];
  logic             col_ok [3];

  assign shift_pix = cmd_i.zero_pix ? '0 : pix_q;
  assign icol_last = (DimW'(icol_q) == w_q - DimW'(1));
  assign ocol_last = (DimW'(ocol_q) == w_q - DimW'(1));
  assign orow_last = (DimW'(orow_q) == h_q - DimW'(1));
  assign frame_end = orow_last && ocol_last;
  assign restart   = cfg_we_i || (cmd_i.load && frame_end);

  // Status to the controller
  always_comb begin
    status_o            = '0;
    status_o.in_done    = (IrowW'(irow_q) >= IrowW'(h_q));
    status_o.emit_due   = (irow_q >= IrowW'(2)) || ((irow_q == IrowW'(1)) && (icol_q != '0));
    status_o.need_shift = (ip_q <= IpW'(op_q) + IpW'(w_q) + IpW'(1));
    status_o.out_free   = !out_valid_q || !out_stall_i;
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= WidthReset;
      h_q <= HeightReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgImageWidth:  w_q <= clamp_dim(cfg_data_i, MaxWidth);
        CfgImageHeight: h_q <= clamp_dim(cfg_data_i, MaxHeight);
        default: ;
      endcase
    end
  end

  // Pixel latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) pix_q <= {red_i, green_i, blue_i};
  end

  // Line stores: registered read at the input column, write on shift
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) above_mem[icol_q] <= shift_pix;
    mid_rd_q <= above_mem[icol_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) two_above_mem[icol_q] <= mid_rd_q;
    top_rd_q <= two_above_mem[icol_q];
  end

  // Window and input position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) win_q[r][c] <= '0;
      icol_q <= '0;
      irow_q <= '0;
      ip_q   <= '0;
    end else if (restart) begin
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++) win_q[r][c] <= '0;
      icol_q <= '0;
      irow_q <= '0;
      ip_q   <= '0;
    end else if (cmd_i.shift) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= top_rd_q;
      win_q[1][2] <= mid_rd_q;
      win_q[2][2] <= shift_pix;
      ip_q <= ip_q + IpW'(1);
      if (icol_last) begin
        icol_q <= '0;
        irow_q <= irow_q + IrowW'(1);
      end else begin
        icol_q <= icol_q + ColW'(1);
      end
    end
  end

  // Output position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ocol_q <= '0;
      orow_q <= '0;
      op_q   <= '0;
    end else if (restart) begin
      ocol_q <= '0;
      orow_q <= '0;
      op_q   <= '0;
    end else if (cmd_i.load) begin
      op_q <= op_q + OpW'(1);
      if (ocol_last) begin
        ocol_q <= '0;
        orow_q <= orow_q + RowW'(1);
      end else begin
        ocol_q <= ocol_q + ColW'(1);
      end
    end
  end

  // Neighborhood sums over the window clipped to the image
  always_comb begin
    row_ok[0] = (orow_q != '0);
    row_ok[1] = 1'b1;
    row_ok[2] = !orow_last;
    col_ok[0] = (ocol_q != '0);
    col_ok[1] = 1'b1;
    col_ok[2] = !ocol_last;
    n_d = '0;
    for (int ch = 0; ch < 3; ch++) sum_d[ch] = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (row_ok[r] && col_ok[c]) begin
          n_d = n_d + NW'(1);
          for (int ch = 0; ch < 3; ch++)
            sum_d[ch] = sum_d[ch] + SumW'(win_q[r][c][PixW-1-ChW*ch -: ChW]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      for (int ch = 0; ch < 3; ch++) sum_q[ch] <= sum_d[ch];
      n_q <= n_d;
    end
  end

  // Rounded mean: (2*sum + n) / (2n) through a reciprocal multiply
  always_comb begin
    logic [XW-1:0]    x;
    logic [ProdW-1:0] prod;
    for (int ch = 0; ch < 3; ch++) begin
      x        = {sum_q[ch], 1'b0} + XW'(n_q);
      prod     = ProdW'(x) * ProdW'(recip(n_q));
      quot[ch] = prod[RecipK +: ChW];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      red_q   <= quot[0];
      green_q <= quot[1];
      blue_q  <= quot[2];
      last_q  <= frame_end;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign red_out_o    = red_q;
  assign green_out_o  = green_q;
  assign blue_out_o   = blue_q;
  assign frame_last_o = last_q;

endmodule

>>> src/box_blur_3x3_edge_averaged.sv
// Top level of the streaming 3x3 box blur with edge-clipped averaging.
//
// Input channel: in_valid_i / in_stall_o carry one beat per pixel in raster order
// (opcode_i = 0) or a flush tick (opcode_i = 1). A beat is taken when valid is high
// and stall is low. Output channel: out_valid_o / out_stall_i carry blurred RGB and
// frame_last_o, set on the final pixel of the frame.
// Results trail the input by one row plus one pixel; after the last pixel of a
// frame, each flush beat yields one of the pending results.
// A pixel beat shifts the window and, when it completes an output, goes on to the
// two-step sum and reciprocal divide, which loads the output register. A flush while
// the frame is still arriving is taken and does nothing. A draining flush shifts the
// window, one shift per flush, two on the first flush of a single-row frame, then sums
// and divides. Each window shift follows a registered read of the line store. No new
// beat is taken until the block has finished with the current one.
// The output register holds a result while the receiver stalls; the next beat is
// processed meanwhile and waits only when its own result is ready.
// Configuration: cfg_we_i writes register cfg_index_i (0 width, 1 height) and
// restarts the frame. Out-of-range values clamp to 1..1024.
// Reset: 640x480, positions and window cleared, output empty; line store contents
// are undefined but never reach a result.
module box_blur_3x3_edge_averaged (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bb3_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [bb3_pkg::DimW-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        opcode_i,
  input  logic [bb3_pkg::ChW-1:0]     red_i,
  input  logic [bb3_pkg::ChW-1:0]     green_i,
  input  logic [bb3_pkg::ChW-1:0]     blue_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [bb3_pkg::ChW-1:0]     red_out_o,
  output logic [bb3_pkg::ChW-1:0]     green_out_o,
  output logic [bb3_pkg::ChW-1:0]     blue_out_o,
  output logic                        frame_last_o
);
  import bb3_pkg::*;

  bb3_cmd_t    cmd;
  bb3_status_t status;

  // Sequencer
  bb3_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath
  bb3_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .red_out_o    (red_out_o),
    .green_out_o  (green_out_o),
    .blue_out_o   (blue_out_o),
    .frame_last_o (frame_last_o)
  );

`ifndef ASSERT_OFF
  // A result is loaded only when the output register can take it
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> (!out_valid_o || !out_stall_i))
    else $error("result loaded over a stalled beat");

  // Output valid rises only after a load
  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.load))
    else $error("output valid without a load");

  // The window never shifts while the input side is open
  a_shift_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.shift |-> in_stall_o)
    else $error("window shift while accepting a beat");
`endif

endmodule

>>> sim/box_blur_3x3_edge_averaged_test.sv
// Self-checking testbench for the streaming 3x3 box blur with edge-clipped averaging.
module box_blur_3x3_edge_averaged_test;
  import bb3_pkg::*;

  localparam logic OpPixel       = 1'b0;
  localparam logic OpFlush       = 1'b1;
  localparam int   WatchdogLimit = 2000;   // cycles with no beat on either side
  localparam int   SettleCycles  = 32;     // covers a flush with two extra shifts
  localparam int   BeatTarget    = 850;

  typedef struct packed {
    logic [ChW-1:0] red;
    logic [ChW-1:0] green;
    logic [ChW-1:0] blue;
    logic           frame_last;
  } blur_px_t;

  // Tracks window and line stores, predicts each blurred pixel and checks the output beats
  class blur_checker;
    bit [PixW-1:0] row_above     [MaxWidth];
    bit [PixW-1:0] row_two_above [MaxWidth];
    bit [PixW-1:0] win [3][3];
    int unsigned   in_pos;
    int unsigned   out_pos;
    int unsigned   width;
    int unsigned   height;
    blur_px_t      blurred_due [$];
    int            errors;

    function new();
      width  = WidthReset;
      height = HeightReset;
      errors = 0;
      restart();
    endfunction

    static function int unsigned clamp_dim(int unsigned v, int unsigned lim);
      if (v < 1) return 1;
      if (v > lim) return lim;
      return v;
    endfunction

    function void restart();
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) win[r][c] = '0;
      end
      in_pos  = 0;
      out_pos = 0;
    endfunction

    // Either register write restarts the frame
    function void write_reg(logic [CfgIdxW-1:0] idx, logic [DimW-1:0] val);
      case (idx)
        CfgImageWidth:  width  = clamp_dim(val, MaxWidth);
        CfgImageHeight: height = clamp_dim(val, MaxHeight);
        default: ;
      endcase
      restart();
    endfunction

    // One window shift: new column from the line stores plus the incoming pixel
    function void slide_window(bit [PixW-1:0] px);
      int unsigned   col;
      bit [PixW-1:0] top;
      bit [PixW-1:0] mid;
      col = (in_pos % width) % MaxWidth;
      top = row_two_above[col];
      mid = row_above[col];
      row_two_above[col] = mid;
      row_above[col]     = px;
      for (int r = 0; r < 3; r++) begin
        win[r][0] = win[r][1];
        win[r][1] = win[r][2];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = px;
      in_pos++;
    endfunction

    // Mean over the clipped neighborhood, rounded half up
    function void average_window();
      int unsigned   orow;
      int unsigned   ocol;
      int unsigned   n;
      int unsigned   sum_r;
      int unsigned   sum_g;
      int unsigned   sum_b;
      bit [PixW-1:0] px;
      blur_px_t      res;
      orow  = out_pos / width;
      ocol  = out_pos % width;
      n     = 0;
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      for (int r = 0; r < 3; r++) begin
        if (r == 0 && orow == 0) continue;
        if (r == 2 && orow + 1 >= height) continue;
        for (int c = 0; c < 3; c++) begin
          if (c == 0 && ocol == 0) continue;
          if (c == 2 && ocol + 1 >= width) continue;
          px = win[r][c];
          sum_r += px[23:16];
          sum_g += px[15:8];
          sum_b += px[7:0];
          n++;
        end
      end
      res.red        = ChW'((2 * sum_r + n) / (2 * n));
      res.green      = ChW'((2 * sum_g + n) / (2 * n));
      res.blue       = ChW'((2 * sum_b + n) / (2 * n));
      res.frame_last = (out_pos + 1 >= width * height);
      if (res.frame_last) restart();
      else out_pos++;
      blurred_due.push_back(res);
    endfunction

    // Accepted input beat
    function void take_beat(logic op, logic [ChW-1:0] r, logic [ChW-1:0] g,
                            logic [ChW-1:0] b);
      int unsigned total;
      int unsigned p;
      total = width * height;
      if (in_pos < total) begin
        // frame still arriving: flush is ignored
        if (op == OpFlush) return;
        p = in_pos;
        slide_window({r, g, b});
        if (p >= width + 1) average_window();
        return;
      end
      // whole frame in: flush or late pixel drains one pending output
      if (out_pos >= total) return;
      while (in_pos <= out_pos + width + 1) slide_window('0);
      average_window();
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // Accepted output beat
    function void check_blurred(blur_px_t got);
      blur_px_t want;
      if (blurred_due.size() == 0) begin
        $display("%0t: unexpected output beat r=%0d g=%0d b=%0d last=%0d", $time,
                 got.red, got.green, got.blue, got.frame_last);
        errors++;
        return;
      end
      want = blurred_due.pop_front();
      compare_field("red_out", want.red, got.red);
      compare_field("green_out", want.green, got.green);
      compare_field("blue_out", want.blue, got.blue);
      compare_field("frame_last", want.frame_last, got.frame_last);
    endfunction

    function int pending();
      return blurred_due.size();
    endfunction
  endclass

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               cfg_we    = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [DimW-1:0]    cfg_data  = '0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic               opcode    = OpPixel;
  logic [ChW-1:0]     red       = '0;
  logic [ChW-1:0]     green     = '0;
  logic [ChW-1:0]     blue      = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [ChW-1:0]     red_out;
  logic [ChW-1:0]     green_out;
  logic [ChW-1:0]     blue_out;
  logic               frame_last;

  blur_checker sb;
  int          gap_pct     = 31;
  int          idle_cycles = 0;
  int          beats_sent  = 0;

  box_blur_3x3_edge_averaged u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .opcode_i     (opcode),
    .red_i        (red),
    .green_i      (green),
    .blue_i       (blue),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .red_out_o    (red_out),
    .green_out_o  (green_out),
    .blue_out_o   (blue_out),
    .frame_last_o (frame_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stalls at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < gap_pct);
  end

  // Beat monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.take_beat(opcode, red, green, blue);
      if (out_valid && !out_stall) sb.check_blurred({red_out, green_out, blue_out, frame_last});
    end
  end

  // Watchdog: too long without any beat
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("[box_blur_3x3_edge_averaged] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One input beat, with random idle cycles ahead of it
  task automatic send_beat(logic op, logic [ChW-1:0] r, logic [ChW-1:0] g,
                           logic [ChW-1:0] b);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    red      <= r;
    green    <= g;
    blue     <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_pixel();
    send_beat(OpPixel, ChW'($urandom_range(255)), ChW'($urandom_range(255)),
              ChW'($urandom_range(255)));
  endtask

  task automatic send_flush();
    send_beat(OpFlush, ChW'($urandom_range(255)), ChW'($urandom_range(255)),
              ChW'($urandom_range(255)));
  endtask

  // Wait until every predicted pixel is out and the block has settled
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_dims(int unsigned w_raw, int unsigned h_raw);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CfgImageWidth;
    cfg_data  <= DimW'(w_raw);
    @(posedge clk);
    sb.write_reg(CfgImageWidth, DimW'(w_raw));
    cfg_index <= CfgImageHeight;
    cfg_data  <= DimW'(h_raw);
    @(posedge clk);
    sb.write_reg(CfgImageHeight, DimW'(h_raw));
    cfg_we <= 1'b0;
  endtask

  // One frame: pixels, then enough flushes to drain it; optional noise or early stop
  task automatic run_frame(int unsigned w_raw, int unsigned h_raw, bit reconfig,
                           bit noisy, bit broken);
    int unsigned w;
    int unsigned h;
    int unsigned total;
    int unsigned stop_at;
    int unsigned drain;
    w     = blur_checker::clamp_dim(w_raw, MaxWidth);
    h     = blur_checker::clamp_dim(h_raw, MaxHeight);
    total = w * h;
    if (reconfig) set_dims(w_raw, h_raw);
    stop_at = broken ? $urandom_range(total - 1) : total;
    for (int unsigned i = 0; i < stop_at; i++) begin
      if (noisy && $urandom_range(9) == 0) send_flush();
      send_pixel();
    end
    if (!broken) begin
      drain = (total < w + 1) ? total : w + 1;
      for (int unsigned i = 0; i < drain; i++) begin
        // a late pixel drains like a flush
        if (noisy && $urandom_range(4) == 0) send_pixel();
        else send_flush();
      end
      if (noisy && $urandom_range(3) == 0) send_flush();
    end
  endtask

  initial begin
    int unsigned w_raw;
    int unsigned h_raw;
    bit          reconfig;
    bit          broken;
    int          frame_no;
    logic [3:0]  k;
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // 3x3 frame with corner colors; flush mid-frame, late pixel, trailing flush
    set_dims(3, 3);
    send_beat(OpFlush, 8'hff, 8'hff, 8'hff);
    for (int i = 0; i < 9; i++) begin
      k = 4'(i);
      if (i == 8) send_beat(OpPixel, 8'h01, 8'hfe, 8'h80);
      else send_beat(OpPixel, {8{k[0]}}, {8{k[1]}}, {8{k[2]}});
      if (i == 4) send_beat(OpFlush, 8'h00, 8'h00, 8'h00);
    end
    send_beat(OpPixel, 8'hff, 8'hff, 8'hff);
    repeat (3) send_beat(OpFlush, 8'h00, 8'h00, 8'h00);
    send_beat(OpFlush, 8'hff, 8'hff, 8'hff);

    // single-row frame: every output comes from a flush
    set_dims(4, 1);
    for (int i = 0; i < 4; i++) send_beat(OpPixel, 8'hff, 8'h00, 8'hff);
    repeat (4) send_beat(OpFlush, 8'h00, 8'h00, 8'h00);

    // dimension extremes and clamping: long frames cut short by the next write
    set_dims(0, 1025);
    repeat (64) send_pixel();
    set_dims(2047, 1);
    repeat (48) send_pixel();
    send_flush();
    run_frame(1, 0, 1'b1, 1'b0, 1'b0);

    // random frames, mostly small, with noise and aborted frames
    frame_no    = 0;
    broken      = 1'b0;
    w_raw       = 1;
    h_raw       = 1;
    while (beats_sent < BeatTarget) begin
      gap_pct  = (frame_no >= 15 && frame_no < 30) ? 0 : 31;
      reconfig = (frame_no == 0) || broken || ($urandom_range(3) != 0);
      if (reconfig) begin
        case ($urandom_range(9))
          0: begin
            w_raw = $urandom_range(40, 9);
            h_raw = $urandom_range(3, 1);
          end
          1: begin
            w_raw = $urandom_range(1) ? 0 : $urandom_range(6, 1);
            h_raw = (w_raw != 0) ? 0 : $urandom_range(6, 1);
          end
          default: begin
            w_raw = $urandom_range(8, 1);
            h_raw = $urandom_range(6, 1);
          end
        endcase
      end
      broken = ($urandom_range(7) == 0);
      run_frame(w_raw, h_raw, reconfig, 1'b1, broken);
      frame_no++;
    end

    gap_pct = 31;
    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[box_blur_3x3_edge_averaged] OK");
    end else begin
      $display("[box_blur_3x3_edge_averaged] ERROR");
    end
    $finish;
  end

endmodule
